/* design/mpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

	// duration field and default count of significant duration bits
	localparam int DUR_W         = 15;
	localparam int DURATION_BITS = 15;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = 3'd4;

	// register reset values
	localparam logic [DUR_W-1:0] SHORT_MIN_RST   = 15'd200;
	localparam logic [DUR_W-1:0] SHORT_MAX_RST   = 15'd700;
	localparam logic [DUR_W-1:0] LONG_MIN_RST    = 15'd701;
	localparam logic [DUR_W-1:0] LONG_MAX_RST    = 15'd1300;
	localparam logic [7:0]       FRAME_BYTES_RST = 8'd8;

	// result status codes
	typedef enum logic [1:0] {
		ST_BYTE     = 2'd0,
		ST_LAST     = 2'd1,
		ST_LIMITS   = 2'd2,
		ST_UNPAIRED = 2'd3
	} status_t;

	localparam int BITS_W = 11;

endpackage

`default_nettype wire

/* design/manchester_pulse_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Manchester decoder on measured pulse widths. Each input item is one line
// pulse (level, duration in ticks); it is classed short or long against the
// inclusive windows in the configuration registers, and bits are assembled
// MSB first into bytes. A result item is produced for every completed byte
// and for every error (zero duration, out-of-window pulse, long after a
// single short); a frame closes after frame_bytes bytes or at the first error.
// Items pass an input register and then a result register: one item per cycle
// is accepted while the input stage does not hold, as set out below.
// The input stage holds only while the item in it has a result and the output
// register still holds a result that has not been taken.
module manchester_pulse_decoder #(
	parameter int DURATION_BITS = mpd_pkg::DURATION_BITS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              cfg_we,
	input  wire  [mpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [mpd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// pulse input
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              level,
	input  wire  [mpd_pkg::DUR_W-1:0]        duration,
	// result output
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [1:0]                       status,
	output logic [7:0]                       data_byte,
	output logic [mpd_pkg::BITS_W-1:0]       bits_decoded,
	output logic                             frame_end
);

	localparam int DW    = mpd_pkg::DUR_W;
	localparam int EFF_W = (DURATION_BITS < DW) ? DURATION_BITS : DW;
	localparam logic [DW-1:0] DUR_MASK = DW'((33'd1 << EFF_W) - 33'd1);

	// configuration registers
	logic [DW-1:0] short_min_q, short_max_q, long_min_q, long_max_q;
	logic [7:0]    frame_bytes_q;

	// input stage
	logic          valid_s1;
	logic          level_s1;
	logic [DW-1:0] dur_s1;

	// decoder state
	logic       half_pending_q;
	logic [7:0] shift_byte_q;
	logic [2:0] bit_index_q;
	logic [7:0] byte_index_q;

	// step logic
	logic       is_short, is_long;
	logic [DW-1:0] dur_eff;
	logic       res_valid;
	logic [1:0] res_status;
	logic [7:0] res_data;
	logic [mpd_pkg::BITS_W-1:0] res_bits;
	logic       res_end;
	logic       nx_half;
	logic [7:0] nx_shift;
	logic [2:0] nx_bit;
	logic [7:0] nx_byte;
	logic [7:0] shift_in;
	logic [7:0] byte_inc;
	logic [7:0] limit;
	logic       take_bit;
	logic       advance;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_min_q   <= mpd_pkg::SHORT_MIN_RST;
			short_max_q   <= mpd_pkg::SHORT_MAX_RST;
			long_min_q    <= mpd_pkg::LONG_MIN_RST;
			long_max_q    <= mpd_pkg::LONG_MAX_RST;
			frame_bytes_q <= mpd_pkg::FRAME_BYTES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpd_pkg::REG_SHORT_MIN:   short_min_q   <= cfg_data;
				mpd_pkg::REG_SHORT_MAX:   short_max_q   <= cfg_data;
				mpd_pkg::REG_LONG_MIN:    long_min_q    <= cfg_data;
				mpd_pkg::REG_LONG_MAX:    long_max_q    <= cfg_data;
				mpd_pkg::REG_FRAME_BYTES: frame_bytes_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// classify the pulse and work out the next state and result
	always_comb begin
		dur_eff  = dur_s1 & DUR_MASK;
		is_short = (dur_eff != '0) && (dur_eff >= short_min_q) && (dur_eff <= short_max_q);
		is_long  = (dur_eff != '0) && (dur_eff >= long_min_q) && (dur_eff <= long_max_q);
		shift_in = {shift_byte_q[6:0], level_s1};
		byte_inc = byte_index_q + 8'd1;
		limit    = (frame_bytes_q == 8'd0) ? 8'd1 : frame_bytes_q;

		nx_half    = half_pending_q;
		nx_shift   = shift_byte_q;
		nx_bit     = bit_index_q;
		nx_byte    = byte_index_q;
		res_valid  = 1'b0;
		res_status = mpd_pkg::ST_LIMITS;
		res_data   = shift_byte_q;
		res_bits   = {byte_index_q, bit_index_q} + mpd_pkg::BITS_W'(1);
		res_end    = 1'b1;
		take_bit   = 1'b0;

		if (half_pending_q) begin
			if (is_short) begin
				nx_half  = 1'b0;
				take_bit = 1'b1;
			end else begin
				res_valid  = 1'b1;
				res_status = is_long ? mpd_pkg::ST_UNPAIRED : mpd_pkg::ST_LIMITS;
			end
		end else if (is_long) begin
			take_bit = 1'b1;
		end else if (is_short) begin
			nx_half = 1'b1;
		end else begin
			res_valid  = 1'b1;
			res_status = mpd_pkg::ST_LIMITS;
		end

		if (take_bit) begin
			nx_shift = shift_in;
			nx_bit   = bit_index_q + 3'd1;
			if (bit_index_q == 3'd7) begin
				// byte complete
				res_valid = 1'b1;
				res_data  = shift_in;
				res_bits  = {byte_inc, 3'b000};
				nx_shift  = '0;
				nx_bit    = '0;
				if (byte_inc >= limit) begin
					res_status = mpd_pkg::ST_LAST;
					res_end    = 1'b1;
					nx_byte    = '0;
				end else begin
					res_status = mpd_pkg::ST_BYTE;
					res_end    = 1'b0;
					nx_byte    = byte_inc;
				end
			end
		end else if (res_valid) begin
			// error: clear the frame
			nx_half  = 1'b0;
			nx_shift = '0;
			nx_bit   = '0;
			nx_byte  = '0;
		end
	end

	// the input stage moves on unless its result would overwrite a waiting one
	assign advance  = valid_s1 && (!res_valid || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// hold input stage and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			half_pending_q <= 1'b0;
			shift_byte_q   <= '0;
			bit_index_q    <= '0;
			byte_index_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				half_pending_q <= nx_half;
				shift_byte_q   <= nx_shift;
				bit_index_q    <= nx_bit;
				byte_index_q   <= nx_byte;
			end
		end
	end

	// capture the item payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= level;
			dur_s1   <= duration;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			status       <= res_status;
			data_byte    <= res_data;
			bits_decoded <= res_bits;
			frame_end    <= res_end;
		end
	end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	import mpd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PARK_CYCLES = 400;
	localparam int GAP_MAX     = 16;

	typedef struct {
		logic             lvl;
		logic [DUR_W-1:0] dur;
	} pulse_t;

	typedef struct {
		status_t           st;
		logic [7:0]        data;
		logic [BITS_W-1:0] bits;
		logic              last;
	} decoded_t;

	typedef enum int {STIM_MIXED, STIM_FRAMES, STIM_LONGS} stim_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  level = 1'b0;
	logic [DUR_W-1:0]      duration = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            status;
	logic [7:0]            data_byte;
	logic [BITS_W-1:0]     bits_decoded;
	logic                  frame_end;

	// pending pulses and expected decoder results
	pulse_t   pulse_q[$];
	decoded_t decoded_q[$];

	// local copy of the pulse windows and frame length
	logic [DUR_W-1:0] win_short_min = SHORT_MIN_RST;
	logic [DUR_W-1:0] win_short_max = SHORT_MAX_RST;
	logic [DUR_W-1:0] win_long_min  = LONG_MIN_RST;
	logic [DUR_W-1:0] win_long_max  = LONG_MAX_RST;
	logic [7:0]       frame_len     = FRAME_BYTES_RST;

	// local copy of the decoder state
	logic       half_pending = 1'b0;
	logic [7:0] shift_byte   = '0;
	int         bit_count    = 0;
	logic [7:0] byte_count   = '0;

	bit          in_take    = 1'b0;
	bit          out_take   = 1'b0;
	bit          park_req   = 1'b0;
	bit          send_burst = 1'b0;
	bit          recv_burst = 1'b0;
	int          send_wait  = 0;
	int          recv_wait  = 0;
	int          park_left  = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	manchester_pulse_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.level        (level),
		.duration     (duration),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.data_byte    (data_byte),
		.bits_decoded (bits_decoded),
		.frame_end    (frame_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic in_window(logic [DUR_W-1:0] d, logic [DUR_W-1:0] lo,
			logic [DUR_W-1:0] hi);
		return d != '0 && d >= lo && d <= hi;
	endfunction

	function automatic void post_result(status_t st, int bits, logic last);
		decoded_t r;
		r.st   = st;
		r.data = shift_byte;
		r.bits = BITS_W'(bits);
		r.last = last;
		decoded_q.push_back(r);
	endfunction

	function automatic void clear_frame();
		half_pending = 1'b0;
		shift_byte   = '0;
		bit_count    = 0;
		byte_count   = '0;
	endfunction

	// errors report the partial byte and count the failed bit position
	function automatic void close_on_error(status_t st);
		post_result(st, int'(byte_count) * 8 + bit_count + 1, 1'b1);
		clear_frame();
	endfunction

	// classify one pulse and advance the frame; queue any result it causes
	function automatic void decode_pulse(logic lvl, logic [DUR_W-1:0] dur);
		logic is_short;
		logic is_long;
		logic take_bit;
		int   limit;
		is_short = in_window(dur, win_short_min, win_short_max);
		is_long  = in_window(dur, win_long_min, win_long_max);
		take_bit = 1'b0;
		// a pending half bit tests short first, otherwise long wins
		if (half_pending) begin
			if (is_short) begin
				half_pending = 1'b0;
				take_bit = 1'b1;
			end else if (is_long) begin
				close_on_error(ST_UNPAIRED);
			end else begin
				close_on_error(ST_LIMITS);
			end
		end else if (is_long) begin
			take_bit = 1'b1;
		end else if (is_short) begin
			half_pending = 1'b1;
		end else begin
			close_on_error(ST_LIMITS);
		end
		if (take_bit) begin
			shift_byte = {shift_byte[6:0], lvl};
			bit_count++;
			if (bit_count == 8) begin
				byte_count = byte_count + 8'd1;
				limit = (frame_len == '0) ? 1 : int'(frame_len);
				if (int'(byte_count) >= limit) begin
					post_result(ST_LAST, int'(byte_count) * 8, 1'b1);
					clear_frame();
				end else begin
					post_result(ST_BYTE, int'(byte_count) * 8, 1'b0);
					shift_byte = '0;
					bit_count  = 0;
				end
			end
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		// cap the log on a badly broken run
		if (mismatch_count <= 100)
			$display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// sample accepted pulses and predict their results
	always @(posedge clk) begin : pulse_sample
		in_take = arst_n && in_valid && in_ready;
		if (in_take)
			decode_pulse(level, duration);
	end

	// present queued pulses with a random gap in front of each item
	always @(negedge clk) begin : pulse_driver
		pulse_t nxt;
		logic   offer;
		if (arst_n && !(in_valid && !in_take)) begin
			if (in_take) begin
				if ($urandom_range(0, 31) == 0)
					send_burst = !send_burst;
				send_wait = send_burst ? 0 : $urandom_range(0, GAP_MAX);
			end
			offer = 1'b0;
			if (send_wait > 0) begin
				send_wait--;
			end else if (pulse_q.size() > 0) begin
				nxt = pulse_q.pop_front();
				level    <= nxt.lvl;
				duration <= nxt.dur;
				offer = 1'b1;
			end
			in_valid <= offer;
		end
	end

	// check each accepted result against the oldest expected one
	always @(posedge clk) begin : result_monitor
		decoded_t want;
		out_take = arst_n && out_valid && out_ready;
		if (out_take) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("result with nothing pending, status", int'(status), -1);
			end else begin
				want = decoded_q.pop_front();
				if (status !== want.st)
					report_mismatch("status", int'(status), int'(want.st));
				if (data_byte !== want.data)
					report_mismatch("data_byte", int'(data_byte), int'(want.data));
				if (bits_decoded !== want.bits)
					report_mismatch("bits_decoded", int'(bits_decoded), int'(want.bits));
				if (frame_end !== want.last)
					report_mismatch("frame_end", int'(frame_end), int'(want.last));
			end
		end
	end

	// stall the result side per item, or park it for a long stretch on request
	always @(negedge clk) begin : result_ready_drive
		if (arst_n) begin
			if (park_req) begin
				park_req  = 1'b0;
				park_left = PARK_CYCLES;
				out_ready <= 1'b0;
			end else if (park_left > 0) begin
				park_left--;
				out_ready <= 1'b0;
			end else begin
				if (out_take) begin
					if ($urandom_range(0, 31) == 0)
						recv_burst = !recv_burst;
					recv_wait = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
				end
				if (recv_wait > 0) begin
					recv_wait--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("manchester_pulse_decoder: mismatch");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		case (idx)
			REG_SHORT_MIN: begin
				win_short_min = val[DUR_W-1:0];
			end
			REG_SHORT_MAX: begin
				win_short_max = val[DUR_W-1:0];
			end
			REG_LONG_MIN: begin
				win_long_min = val[DUR_W-1:0];
			end
			REG_LONG_MAX: begin
				win_long_max = val[DUR_W-1:0];
			end
			REG_FRAME_BYTES: begin
				frame_len = val[7:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every pulse is taken and every result has come, then let the pipe empty
	task automatic wait_drained();
		while (pulse_q.size() != 0 || in_valid || decoded_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void push_pulse(logic lvl, logic [DUR_W-1:0] dur);
		pulse_t p;
		p.lvl = lvl;
		p.dur = dur;
		pulse_q.push_back(p);
	endfunction

	// pick a duration in a window, often at one of its edges
	function automatic logic [DUR_W-1:0] pick_in(logic [DUR_W-1:0] lo, logic [DUR_W-1:0] hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return DUR_W'($urandom_range(int'(hi), int'(lo)));
		endcase
	endfunction

	// pick a duration outside both windows, falling back to packet end
	function automatic logic [DUR_W-1:0] pick_bad();
		logic [DUR_W-1:0] d;
		repeat (8) begin
			case ($urandom_range(0, 2))
				0: d = win_short_min - 1'b1;
				1: d = win_long_max + 1'b1;
				default: d = DUR_W'($urandom_range(0, 32767));
			endcase
			if (!in_window(d, win_short_min, win_short_max) &&
					!in_window(d, win_long_min, win_long_max))
				return d;
		end
		return '0;
	endfunction

	// one byte of well-formed bits, each as a long or as a short pair
	function automatic void push_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		for (int i = 7; i >= 0; i--) begin
			if ($urandom_range(0, 2) == 0) begin
				push_pulse(1'($urandom_range(0, 1)), pick_in(win_short_min, win_short_max));
				push_pulse(b[i], pick_in(win_short_min, win_short_max));
			end else begin
				push_pulse(b[i], pick_in(win_long_min, win_long_max));
			end
		end
	endfunction

	task automatic fill_pulses(int n, stim_t mode);
		int start;
		int r;
		start = pulse_q.size();
		while (pulse_q.size() - start < n) begin
			r = $urandom_range(0, 99);
			if (mode == STIM_LONGS) begin
				push_pulse(1'($urandom_range(0, 1)), pick_in(win_long_min, win_long_max));
			end else if (mode == STIM_FRAMES || r < 65) begin
				push_byte();
			end else if (r < 75) begin
				push_pulse(1'($urandom_range(0, 1)), pick_in(win_short_min, win_short_max));
				push_pulse(1'($urandom_range(0, 1)), pick_in(win_short_min, win_short_max));
			end else if (r < 87) begin
				// broken pair: short then long or out of window
				push_pulse(1'($urandom_range(0, 1)), pick_in(win_short_min, win_short_max));
				push_pulse(1'($urandom_range(0, 1)),
					$urandom_range(0, 1) ? pick_in(win_long_min, win_long_max) : pick_bad());
			end else begin
				push_pulse(1'($urandom_range(0, 1)),
					($urandom_range(0, 7) == 0) ? '0 : DUR_W'($urandom_range(0, 32767)));
			end
		end
	endtask

	task automatic run_phase(int smin, int smax, int lmin, int lmax, int fb, int n,
			stim_t mode);
		write_reg(REG_SHORT_MIN, smin);
		write_reg(REG_SHORT_MAX, smax);
		write_reg(REG_LONG_MIN, lmin);
		write_reg(REG_LONG_MAX, lmax);
		write_reg(REG_FRAME_BYTES, fb);
		@(posedge clk);
		fill_pulses(n, mode);
		if (mode == STIM_LONGS)
			park_req = 1'b1;
		wait_drained();
	endtask

	initial begin : stimulus
		int a;
		int b;
		int c;
		int d;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pulses on the reset windows
		push_pulse(1'b1, 15'd701);
		push_pulse(1'b0, 15'd1300);
		push_pulse(1'b0, 15'd200);
		push_pulse(1'b1, 15'd700);
		repeat (5) push_pulse(1'b1, 15'd1000);
		// long after short
		push_pulse(1'b0, 15'd450);
		push_pulse(1'b1, 15'd900);
		// short then out of window
		push_pulse(1'b1, 15'd300);
		push_pulse(1'b0, 15'd1301);
		// packet end and limits just outside the windows
		push_pulse(1'b1, 15'd0);
		push_pulse(1'b0, 15'd32767);
		push_pulse(1'b1, 15'd199);
		push_pulse(1'b0, 15'd1);
		push_pulse(1'b1, 15'd701);
		push_pulse(1'b0, 15'h5555);
		wait_drained();

		// overlapping windows with frame length zero
		run_phase(100, 900, 500, 1500, 0, 200, STIM_MIXED);
		// narrowest short window, widest long window, one byte frames
		run_phase(1, 1, 2, 32767, 1, 200, STIM_MIXED);
		run_phase(0, 32767, 0, 32767, 3, 150, STIM_MIXED);
		// longest frame, then lower the length with the frame still open
		run_phase(32767, 32767, 16384, 32766, 255, 250, STIM_FRAMES);
		run_phase(32767, 32767, 16384, 32766, 2, 100, STIM_FRAMES);
		// long pulses while the result side is parked
		run_phase(200, 700, 701, 1300, 4, 200, STIM_LONGS);

		repeat (4) begin
			a = $urandom_range(1, 2000);
			b = a + $urandom_range(0, 2000);
			c = b + $urandom_range(0, 200) - 50;
			d = c + $urandom_range(0, 30000);
			if (d > 32767)
				d = 32767;
			run_phase(a, b, c, d, $urandom_range(1, 12), 150, STIM_MIXED);
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("manchester_pulse_decoder: match");
		end else begin
			$display("manchester_pulse_decoder: mismatch");
		end
		$finish;
	end

endmodule
